// ===== src/kprq_pkg.sv =====
// Package with the command, status and sequencer state types of the keyed pair queue.
`default_nettype none

package kprq_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned ENTRY_W = 2 * WORD_W;

	typedef enum logic [2:0] {
		CMD_ENQ  = 3'd0,
		CMD_DEQ  = 3'd1,
		CMD_PEEK = 3'd2,
		CMD_FIND = 3'd3,
		CMD_GET  = 3'd4,
		CMD_SET  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEAD,
		S_SEARCH,
		S_SWAP,
		S_RESP
	} state_t;

	localparam logic [WORD_W-1:0] NONE_WORD = '1;

endpackage

`default_nettype wire

// ===== src/kprq_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module kprq_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/keyed_pair_ring_queue_top.sv =====
// Top level of the keyed pair ring queue: sequencer, pointers and the entry RAM.
//
// Usage: a command transaction on the input channel (cmd, key, value_in) gives exactly
// one result transaction on the output channel (out_key, out_value, hit, status,
// entry_count, is_empty, is_full). Both channels use valid and ready.
// The block works on one command at a time. Enqueue, unused codes and commands on an
// empty queue go straight to the response state; dequeue and peek first read the
// head entry from the RAM.
// Key searches read one stored entry per cycle through the single RAM read port and
// stop at the first match or after entry_count entries; find-and-dequeue passes through
// a swap state when it has to move the head entry into the found slot.
// The input is ready again in the same cycle as the result appears in the output
// register, so a new command is taken while an earlier result still waits there.
// If the receiver stalls, the finished result of the next command waits in the
// sequencer until the output register frees.
// Reset empties the queue (pointers and count to zero) and drops any pending result;
// the RAM contents are not cleared and are only read after being written.
`default_nettype none

module keyed_pair_ring_queue_top
	import kprq_pkg::*;
#(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic        [2:0]                 cmd,
	input  wire logic signed [WORD_W-1:0]          key,
	input  wire logic signed [WORD_W-1:0]          value_in,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed      [WORD_W-1:0]          out_key,
	output logic signed      [WORD_W-1:0]          out_value,
	output logic                                   hit,
	output logic             [1:0]                 status,
	output logic             [$clog2(CAPACITY+1)-1:0] entry_count,
	output logic                                   is_empty,
	output logic                                   is_full
);

	localparam int unsigned PTR_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	state_t state_q, state_d;
	cmd_t cmd_q;
	logic [WORD_W-1:0] key_q, val_q;
	logic [PTR_W-1:0] head_q, tail_q, rd_ptr_q, slot_s1, found_slot_q;
	logic [CNT_W-1:0] count_q, issued_q;
	logic [WORD_W-1:0] res_key_q, res_val_q;
	logic res_hit_q;
	status_t res_st_q;

	logic accept, load, q_empty, q_full, match, pop;
	logic mem_we, mem_re;
	logic [PTR_W-1:0] mem_waddr, mem_raddr;
	logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
	logic [WORD_W-1:0] rd_key, rd_val;

	kprq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_entry_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign rd_key = mem_rdata[ENTRY_W-1:WORD_W];
	assign rd_val = mem_rdata[WORD_W-1:0];
	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign load = (state_q == S_RESP) && (!out_valid || out_ready);
	assign q_empty = (count_q == '0);
	assign q_full = (count_q == FULL_CNT);
	assign match = (rd_key == key_q);

	always_comb begin
		state_d = state_q;
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re = 1'b0;
		mem_raddr = '0;
		pop = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_RESP;
					case (cmd) inside
						CMD_ENQ: begin
							if (!q_full) begin
								mem_we = 1'b1;
								mem_waddr = tail_q;
								mem_wdata = {key, value_in};
							end
						end
						CMD_DEQ, CMD_PEEK: begin
							if (!q_empty) begin
								mem_re = 1'b1;
								mem_raddr = head_q;
								state_d = S_HEAD;
							end
						end
						CMD_FIND, CMD_GET, CMD_SET: begin
							if (!q_empty) begin
								mem_re = 1'b1;
								mem_raddr = head_q;
								state_d = S_SEARCH;
							end
						end
						default: ;
					endcase
				end
			end
			S_HEAD: begin
				pop = (cmd_q == CMD_DEQ);
				state_d = S_RESP;
			end
			S_SEARCH: begin
				if (match) begin
					state_d = S_RESP;
					case (cmd_q)
						CMD_FIND: begin
							if (slot_s1 == head_q) begin
								pop = 1'b1;
							end else begin
								mem_re = 1'b1;
								mem_raddr = head_q;
								state_d = S_SWAP;
							end
						end
						CMD_SET: begin
							mem_we = 1'b1;
							mem_waddr = slot_s1;
							mem_wdata = {key_q, val_q};
						end
						default: ;
					endcase
				end else if (issued_q == count_q) begin
					state_d = S_RESP;
				end else begin
					mem_re = 1'b1;
					mem_raddr = rd_ptr_q;
				end
			end
			S_SWAP: begin
				mem_we = 1'b1;
				mem_waddr = found_slot_q;
				mem_wdata = mem_rdata;
				pop = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_valid || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && (cmd == CMD_ENQ) && !q_full) begin
				tail_q <= next_slot(tail_q);
				count_q <= count_q + 1'b1;
			end else if (pop) begin
				head_q <= next_slot(head_q);
				count_q <= count_q - 1'b1;
			end
			if (load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q <= cmd_t'(cmd);
					key_q <= key;
					val_q <= value_in;
					res_key_q <= NONE_WORD;
					res_val_q <= NONE_WORD;
					res_hit_q <= 1'b0;
					rd_ptr_q <= next_slot(head_q);
					issued_q <= CNT_W'(1);
					slot_s1 <= head_q;
					if (cmd == CMD_ENQ) begin
						res_st_q <= q_full ? ST_FULL : ST_OK;
					end else if ((cmd <= CMD_SET) && q_empty) begin
						res_st_q <= ST_EMPTY;
					end else begin
						res_st_q <= ST_OK;
					end
				end
			end
			S_HEAD: begin
				res_key_q <= rd_key;
				res_val_q <= rd_val;
				res_hit_q <= 1'b1;
			end
			S_SEARCH: begin
				if (match) begin
					found_slot_q <= slot_s1;
					res_key_q <= key_q;
					res_val_q <= (cmd_q == CMD_SET) ? val_q : rd_val;
					res_hit_q <= 1'b1;
				end else if (issued_q == count_q) begin
					res_st_q <= ST_MISS;
				end else begin
					slot_s1 <= rd_ptr_q;
					rd_ptr_q <= next_slot(rd_ptr_q);
					issued_q <= issued_q + 1'b1;
				end
			end
			S_RESP: begin
				if (load) begin
					out_key <= res_key_q;
					out_value <= res_val_q;
					hit <= res_hit_q;
					status <= res_st_q;
					entry_count <= count_q;
					is_empty <= q_empty;
					is_full <= q_full;
				end
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_CNT)
		else $error("Entry count exceeds the queue capacity.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(q_empty || q_full) |-> (head_q == tail_q))
		else $error("Head and tail pointers disagree with an empty or full queue.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> (status == ST_OK))
		else $error("A result reports a returned entry with a failure status.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd == CMD_ENQ) && !q_full) |=>
		(count_q == CNT_W'($past(count_q) + 1'b1)))
		else $error("An accepted enqueue did not add one entry.");

endmodule

`default_nettype wire

// ===== tb/keyed_pair_ring_queue_top_test.sv =====
// Self-checking testbench of the keyed pair ring queue, with its own queue predictor.
`timescale 1ns / 100ps

module keyed_pair_ring_queue_top_test
	import kprq_pkg::*;
;

	localparam int QCAP = 16;
	localparam int RESET_CYCLES = 7;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 1800;
	localparam int TRAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [2:0] CMD_UNUSED6 = 3'd6;
	localparam logic [2:0] CMD_UNUSED7 = 3'd7;

	typedef struct packed {
		logic [WORD_W-1:0] rkey;
		logic [WORD_W-1:0] rval;
		logic              hit;
		status_t           st;
		logic [4:0]        count;
		logic              empty;
		logic              full;
	} queue_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [2:0] cmd;
	logic signed [WORD_W-1:0] key;
	logic signed [WORD_W-1:0] value_in;
	logic out_valid;
	logic out_ready;
	logic signed [WORD_W-1:0] out_key;
	logic signed [WORD_W-1:0] out_value;
	logic hit;
	logic [1:0] status;
	logic [4:0] entry_count;
	logic is_empty;
	logic is_full;

	logic [WORD_W-1:0] q_key [QCAP];
	logic [WORD_W-1:0] q_val [QCAP];
	int q_head = 0;
	int q_tail = 0;
	int q_count = 0;

	queue_result_t pending_results [$];
	queue_result_t expected_result;
	int error_count = 0;
	int cycle_count = 0;
	bit rx_hold_req = 1'b0;
	int rx_hold_left = 0;
	int rx_calm_left = 0;
	int rx_gap_left = 0;

	keyed_pair_ring_queue_top #(
		.CAPACITY(QCAP)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.key(key),
		.value_in(value_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_key(out_key),
		.out_value(out_value),
		.hit(hit),
		.status(status),
		.entry_count(entry_count),
		.is_empty(is_empty),
		.is_full(is_full)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic queue_result_t queue_model_step(input logic [2:0] c,
			input logic [WORD_W-1:0] k, input logic [WORD_W-1:0] v);
		queue_result_t r;
		int slot;
		int p;
		bit found;
		logic [WORD_W-1:0] tk;
		logic [WORD_W-1:0] tv;
		r.rkey = NONE_WORD;
		r.rval = NONE_WORD;
		r.hit = 1'b0;
		r.st = ST_OK;
		slot = 0;
		found = 1'b0;
		p = q_head;
		for (int n = 0; n < q_count; n++) begin
			if (!found && q_key[p] == k) begin
				found = 1'b1;
				slot = p;
			end
			p = (p + 1) % QCAP;
		end
		if (c == CMD_ENQ) begin
			if (q_count >= QCAP) begin
				r.st = ST_FULL;
			end else begin
				q_key[q_tail] = k;
				q_val[q_tail] = v;
				q_tail = (q_tail + 1) % QCAP;
				q_count++;
			end
		end else if (c <= CMD_SET) begin
			if (q_count == 0) begin
				r.st = ST_EMPTY;
			end else if (c == CMD_DEQ || c == CMD_PEEK) begin
				r.rkey = q_key[q_head];
				r.rval = q_val[q_head];
				r.hit = 1'b1;
				if (c == CMD_DEQ) begin
					q_head = (q_head + 1) % QCAP;
					q_count--;
				end
			end else if (!found) begin
				r.st = ST_MISS;
			end else if (c == CMD_FIND) begin
				tk = q_key[q_head];
				tv = q_val[q_head];
				q_key[q_head] = q_key[slot];
				q_val[q_head] = q_val[slot];
				q_key[slot] = tk;
				q_val[slot] = tv;
				r.rkey = q_key[q_head];
				r.rval = q_val[q_head];
				r.hit = 1'b1;
				q_head = (q_head + 1) % QCAP;
				q_count--;
			end else begin
				if (c == CMD_SET)
					q_val[slot] = v;
				r.rkey = q_key[slot];
				r.rval = q_val[slot];
				r.hit = 1'b1;
			end
		end
		r.count = q_count[4:0];
		r.empty = (q_count == 0);
		r.full = (q_count >= QCAP);
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// Called at a falling edge; returns at a falling edge with valid still high when gap is zero.
	task automatic send_item(input logic [2:0] c, input logic [WORD_W-1:0] k,
			input logic [WORD_W-1:0] v, input int gap);
		in_valid <= 1'b1;
		cmd <= c;
		key <= k;
		value_in <= v;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.push_back(queue_model_step(c, k, v));
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result transaction, expected none, actual key %0h",
					$time, out_key);
				error_count++;
			end else begin
				expected_result = pending_results.pop_front();
				check_field("out_key", expected_result.rkey, out_key);
				check_field("out_value", expected_result.rval, out_value);
				check_field("hit", WORD_W'(expected_result.hit), WORD_W'(hit));
				check_field("status", WORD_W'(expected_result.st), WORD_W'(status));
				check_field("entry_count", WORD_W'(expected_result.count),
					WORD_W'(entry_count));
				check_field("is_empty", WORD_W'(expected_result.empty), WORD_W'(is_empty));
				check_field("is_full", WORD_W'(expected_result.full), WORD_W'(is_full));
			end
		end
	end

	initial begin
		int r;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				rx_hold_left = RX_HOLD_CYCLES;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_ready <= 1'b0;
			end else if (rx_calm_left > 0) begin
				rx_calm_left--;
				out_ready <= 1'b1;
			end else if (rx_gap_left > 0) begin
				rx_gap_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				r = $urandom_range(0, 99);
				if (r < 5)
					rx_calm_left = $urandom_range(20, 80);
				else if (r < 30)
					rx_gap_left = $urandom_range(1, 3);
				else if (r < 33)
					rx_gap_left = $urandom_range(10, 60);
			end
		end
	end

	task automatic test_empty_queue();
		send_item(CMD_DEQ, $urandom, $urandom, pick_gap());
		send_item(CMD_PEEK, $urandom, $urandom, pick_gap());
		send_item(CMD_FIND, $urandom, $urandom, pick_gap());
		send_item(CMD_GET, $urandom, $urandom, pick_gap());
		send_item(CMD_SET, $urandom, $urandom, pick_gap());
		send_item(CMD_UNUSED6, $urandom, $urandom, pick_gap());
		send_item(CMD_UNUSED7, $urandom, $urandom, pick_gap());
	endtask

	task automatic test_basic_commands();
		send_item(CMD_ENQ, 32'h8000_0000, 32'h7fff_ffff, pick_gap());
		send_item(CMD_ENQ, 32'h7fff_ffff, 32'h8000_0000, pick_gap());
		send_item(CMD_ENQ, 32'hffff_ffff, 32'h0, pick_gap());
		send_item(CMD_ENQ, 32'h0, 32'hffff_ffff, pick_gap());
		send_item(CMD_ENQ, 32'd5, 32'd55, pick_gap());
		send_item(CMD_ENQ, 32'd5, 32'd66, pick_gap());
		send_item(CMD_PEEK, $urandom, $urandom, pick_gap());
		send_item(CMD_GET, 32'd5, $urandom, pick_gap());
		send_item(CMD_SET, 32'd5, 32'd77, pick_gap());
		send_item(CMD_GET, 32'd5, $urandom, pick_gap());
		// The match sits behind the head, so the head entry moves into its slot.
		send_item(CMD_FIND, 32'h0, $urandom, pick_gap());
		send_item(CMD_FIND, 32'h7fff_ffff, $urandom, pick_gap());
		send_item(CMD_FIND, 32'd1234, $urandom, pick_gap());
		send_item(CMD_GET, 32'd1234, $urandom, pick_gap());
		send_item(CMD_SET, 32'd1234, $urandom, pick_gap());
		send_item(CMD_DEQ, $urandom, $urandom, pick_gap());
		send_item(CMD_GET, 32'h8000_0000, $urandom, pick_gap());
		send_item(CMD_UNUSED6, $urandom, $urandom, pick_gap());
		send_item(CMD_UNUSED7, $urandom, $urandom, pick_gap());
		send_item(CMD_DEQ, $urandom, $urandom, pick_gap());
	endtask

	task automatic test_backpressure();
		rx_hold_req = 1'b1;
		repeat (QCAP + 4)
			send_item(CMD_ENQ, $urandom, $urandom, 0);
		send_item(CMD_FIND, q_key[(q_tail + QCAP - 1) % QCAP], $urandom, 0);
		while (q_count > 0)
			send_item(CMD_DEQ, $urandom, $urandom, 0);
		wait_results_drained();
	endtask

	task automatic test_random();
		cmd_t other_cmds [5];
		int sent;
		int phase_left;
		int enq_pct;
		int r;
		bit burst;
		logic [2:0] c;
		logic [WORD_W-1:0] k;
		other_cmds = '{CMD_DEQ, CMD_PEEK, CMD_FIND, CMD_GET, CMD_SET};
		sent = 0;
		phase_left = 0;
		enq_pct = 40;
		burst = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(10, 60);
				case ($urandom_range(0, 2))
					0: enq_pct = 75;
					1: enq_pct = 15;
					default: enq_pct = 40;
				endcase
				burst = ($urandom_range(0, 4) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < 2)
				c = r[0] ? CMD_UNUSED7 : CMD_UNUSED6;
			else if (r < enq_pct + 2)
				c = CMD_ENQ;
			else
				c = other_cmds[$urandom_range(0, 4)];
			r = $urandom_range(0, 99);
			if (c != CMD_ENQ && r < 60 && q_count > 0)
				k = q_key[(q_head + $urandom_range(0, q_count - 1)) % QCAP];
			else if (r < 85)
				k = 32'($urandom_range(0, 7)) - 32'd4;
			else
				k = $urandom;
			send_item(c, k, $urandom, burst ? 0 : pick_gap());
			sent++;
			phase_left--;
			if ($urandom_range(0, 99) == 0)
				wait_results_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_ENQ;
		key = '0;
		value_in = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_queue();
		test_basic_commands();
		test_backpressure();
		test_random();
		wait_results_drained();
		repeat (TRAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
